// File: design/spmt_pkg.sv
// Shared types and constants for the slot pool motion table.
package spmt_pkg;

   localparam int SLOTS_DEF = 16;
   localparam int CSR_IDX_W = 2;
   localparam int MASK_OUT_W = 16;
   localparam int SLOT_OUT_W = 4;

   localparam logic [2:0] CMD_CLEAR = 3'd0;
   localparam logic [2:0] CMD_SPAWN = 3'd1;
   localparam logic [2:0] CMD_FREE  = 3'd2;
   localparam logic [2:0] CMD_TICK  = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM = 2'd3;

   localparam logic signed [15:0] LEFT_RST   = -16'sd8;
   localparam logic signed [15:0] RIGHT_RST  = 16'sd167;
   localparam logic signed [15:0] TOP_RST    = -16'sd8;
   localparam logic signed [15:0] BOTTOM_RST = 16'sd159;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [15:0] new_x;
      logic signed [15:0] new_y;
      logic signed [7:0]  new_vx;
      logic signed [7:0]  new_vy;
      logic [3:0]         slot_index;
   } req_type;

   typedef struct packed {
      logic               result_status;
      logic [3:0]         result_slot;
      logic [15:0]        active_mask;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [7:0]  vel_x;
      logic signed [7:0]  vel_y;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [7:0]  vx;
      logic signed [7:0]  vy;
   } entry_type;

   typedef struct packed {
      logic signed [15:0] left_bound;
      logic signed [15:0] right_bound;
      logic signed [15:0] top_bound;
      logic signed [15:0] bottom_bound;
   } bounds_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic clr;
   } mem_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_READ
   } state_type;

endpackage

// File: design/spmt_entry_mem.sv
// Entry memory: one write port, one registered read port, per-entry valid bits.
module spmt_entry_mem #(
   parameter int SLOTS = spmt_pkg::SLOTS_DEF,
   parameter int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spmt_pkg::mem_cmd_type mem_cmd,
   input  logic [SW-1:0]         wr_idx,
   input  spmt_pkg::entry_type   wr_data,
   input  logic [SW-1:0]         rd_idx,
   output spmt_pkg::entry_type   rd_data
);
   import spmt_pkg::*;

   entry_type        mem_ff [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   entry_type        rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || mem_cmd.clr) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_cmd.wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (mem_cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: design/spmt_ctrl.sv
// Command sequencer: occupancy mask, tick walk over the entry memory, result register.
module spmt_ctrl #(
   parameter int SLOTS = spmt_pkg::SLOTS_DEF,
   parameter int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  spmt_pkg::req_type     req_word,
   input  spmt_pkg::bounds_type  bounds,
   output spmt_pkg::mem_cmd_type mem_cmd,
   output logic [SW-1:0]         wr_idx,
   output spmt_pkg::entry_type   wr_data,
   output logic [SW-1:0]         rd_idx,
   input  spmt_pkg::entry_type   rd_data,
   output logic                  rsp_strobe,
   output spmt_pkg::rsp_type     rsp_word
);
   import spmt_pkg::*;

   state_type        state_ff, state_in;
   logic [SLOTS-1:0] mask_ff, mask_in;
   logic [SW-1:0]    scan_ff, scan_in;
   logic             pipe_vld_ff, pipe_vld_in;
   logic [SW-1:0]    pipe_idx_ff, pipe_idx_in;
   logic [3:0]       slot_ff, slot_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   logic               accept;
   logic               idx_ok;
   logic               free_found;
   logic [SW-1:0]      free_idx;
   logic [SW-1:0]      req_idx;
   logic signed [15:0] nx, ny;
   logic               out_of_bounds;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign idx_ok  = (32'(req_word.slot_index) < SLOTS);
   assign req_idx = SW'(req_word.slot_index);

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!mask_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   assign nx = rd_data.x + 16'(rd_data.vx);
   assign ny = rd_data.y + 16'(rd_data.vy);
   assign out_of_bounds = (nx < bounds.left_bound) || (nx > bounds.right_bound) ||
                          (ny < bounds.top_bound) || (ny > bounds.bottom_bound);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_word.command == CMD_TICK) begin
               state_in = ST_SCAN;
            end else if (accept && req_word.command == CMD_READ && idx_ok) begin
               state_in = ST_READ;
            end
         end
         ST_SCAN: begin
            if (scan_ff == SW'(SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_IDLE;
         ST_READ:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mem_cmd       = '0;
      wr_idx        = '0;
      wr_data       = '0;
      rd_idx        = '0;
      mask_in       = mask_ff;
      scan_in       = scan_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = pipe_idx_ff;
      slot_in       = slot_ff;
      rsp_in        = '0;
      rsp_strobe_in = 1'b0;

      if (pipe_vld_ff && mask_ff[pipe_idx_ff]) begin
         mem_cmd.wr_en = 1'b1;
         wr_idx        = pipe_idx_ff;
         wr_data       = '{x: nx, y: ny, vx: rd_data.vx, vy: rd_data.vy};
         if (out_of_bounds) begin
            mask_in[pipe_idx_ff] = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               case (req_word.command)
                  CMD_CLEAR: begin
                     mem_cmd.clr = 1'b1;
                     mask_in     = '0;
                  end
                  CMD_SPAWN: begin
                     if (free_found) begin
                        mem_cmd.wr_en     = 1'b1;
                        wr_idx            = free_idx;
                        wr_data           = '{x: req_word.new_x, y: req_word.new_y,
                                              vx: req_word.new_vx, vy: req_word.new_vy};
                        mask_in[free_idx] = 1'b1;
                        rsp_in.result_slot = SLOT_OUT_W'(free_idx);
                     end else begin
                        rsp_in.result_status = 1'b1;
                     end
                  end
                  CMD_FREE: begin
                     if (idx_ok) begin
                        mask_in[req_idx] = 1'b0;
                     end
                  end
                  CMD_TICK: begin
                     rsp_strobe_in = 1'b0;
                     scan_in       = '0;
                  end
                  CMD_READ: begin
                     rsp_in.result_slot = req_word.slot_index;
                     slot_in            = req_word.slot_index;
                     if (idx_ok) begin
                        rsp_strobe_in  = 1'b0;
                        mem_cmd.rd_en  = 1'b1;
                        rd_idx         = req_idx;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            mem_cmd.rd_en = 1'b1;
            rd_idx        = scan_ff;
            pipe_vld_in   = 1'b1;
            pipe_idx_in   = scan_ff;
            scan_in       = scan_ff + SW'(1);
         end
         ST_DRAIN: begin
            rsp_strobe_in = 1'b1;
         end
         ST_READ: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.result_slot = slot_ff;
            rsp_in.pos_x       = rd_data.x;
            rsp_in.pos_y       = rd_data.y;
            rsp_in.vel_x       = rd_data.vx;
            rsp_in.vel_y       = rd_data.vy;
         end
         default: begin
         end
      endcase

      rsp_in.active_mask = MASK_OUT_W'(mask_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mask_ff       <= '0;
         scan_ff       <= '0;
         pipe_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mask_ff       <= mask_in;
         scan_ff       <= scan_in;
         pipe_vld_ff   <= pipe_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_idx_ff <= pipe_idx_in;
      slot_ff     <= slot_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// File: design/slot_pool_motion_table.sv
// Top level of the slot pool motion table: bound registers, sequencer and entry memory.
//
// Commands enter on req_word, taken at a clock edge where start is high and busy is
// low. Each command yields one result word on rsp_word, marked by rsp_strobe for one
// cycle; the receiver cannot hold it off and the block never waits on it.
// Clear, spawn, free, unknown commands and reads of a slot past the pool: the result
// shows the cycle after the command is taken, and busy stays low, so one such
// command can be taken every cycle.
// Read of a slot in the pool: the entry passes through the registered memory read and
// then the result register, and busy is high while the read is under way.
// Tick: the sequencer reads one slot per cycle and writes the moved entry back in the
// cycle after its read; the result follows the last write-back, and busy stays high
// through the walk and write-back; the entry memory port sets that rate.
// The bound registers are written through csr_wen, csr_index and csr_wdata at any
// edge with csr_wen high, and are meant to change only while the block is idle.
// Reset empties the occupancy mask, marks every entry as reading zero and loads the
// bound registers with their defaults; the block takes commands in the next cycle.
module slot_pool_motion_table #(
   parameter int SLOTS = spmt_pkg::SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  spmt_pkg::req_type                   req_word,
   output logic                                rsp_strobe,
   output spmt_pkg::rsp_type                   rsp_word,
   input  logic                                csr_wen,
   input  logic [spmt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [15:0]                         csr_wdata
);
   import spmt_pkg::*;

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   bounds_type  bounds_ff;
   mem_cmd_type mem_cmd;
   logic [SW-1:0] wr_idx;
   logic [SW-1:0] rd_idx;
   entry_type   wr_data;
   entry_type   rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff <= '{left_bound: LEFT_RST, right_bound: RIGHT_RST,
                        top_bound: TOP_RST, bottom_bound: BOTTOM_RST};
      end else if (csr_wen) begin
         case (csr_index)
            CSR_LEFT:   bounds_ff.left_bound   <= csr_wdata;
            CSR_RIGHT:  bounds_ff.right_bound  <= csr_wdata;
            CSR_TOP:    bounds_ff.top_bound    <= csr_wdata;
            CSR_BOTTOM: bounds_ff.bottom_bound <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   spmt_ctrl #(
      .SLOTS (SLOTS),
      .SW    (SW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .bounds     (bounds_ff),
      .mem_cmd    (mem_cmd),
      .wr_idx     (wr_idx),
      .wr_data    (wr_data),
      .rd_idx     (rd_idx),
      .rd_data    (rd_data),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   spmt_entry_mem #(
      .SLOTS (SLOTS),
      .SW    (SW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_cmd (mem_cmd),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

endmodule

// File: tb/sv/motion_table_checker.sv
// Checker for the slot pool motion table: tracks the pool, predicts each result and compares.
module motion_table_checker
   import spmt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req_word,
   input  logic                 rsp_strobe,
   input  rsp_type              rsp_word,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata,
   output int                   mismatch_count,
   output int                   pending
);

   localparam int SLOTS = SLOTS_DEF;

   logic [SLOTS-1:0] occupied;
   entry_type        entries [SLOTS];
   bounds_type       bounds;
   rsp_type          awaited_words [$];
   rsp_type          want;
   int               errors = 0;
   int               outstanding = 0;

   assign mismatch_count = errors;
   assign pending = outstanding;

   function automatic rsp_type advance_pool(req_type r);
      rsp_type            o;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      int                 slot;
      o = '0;
      case (r.command)
         CMD_CLEAR: begin
            occupied = '0;
            foreach (entries[i]) entries[i] = '0;
         end
         CMD_SPAWN: begin
            slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!occupied[i]) slot = i;
            end
            if (slot < 0) begin
               o.result_status = 1'b1;
            end else begin
               occupied[slot] = 1'b1;
               entries[slot].x = r.new_x;
               entries[slot].y = r.new_y;
               entries[slot].vx = r.new_vx;
               entries[slot].vy = r.new_vy;
               o.result_slot = slot[3:0];
            end
         end
         CMD_FREE: begin
            if (r.slot_index < SLOTS) occupied[r.slot_index] = 1'b0;
         end
         CMD_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (occupied[i]) begin
                  nx = entries[i].x + 16'(entries[i].vx);
                  ny = entries[i].y + 16'(entries[i].vy);
                  entries[i].x = nx;
                  entries[i].y = ny;
                  if (nx < $signed(bounds.left_bound) || nx > $signed(bounds.right_bound) ||
                      ny < $signed(bounds.top_bound) || ny > $signed(bounds.bottom_bound)) begin
                     occupied[i] = 1'b0;
                  end
               end
            end
         end
         CMD_READ: begin
            o.result_slot = r.slot_index;
            if (r.slot_index < SLOTS) begin
               o.pos_x = entries[r.slot_index].x;
               o.pos_y = entries[r.slot_index].y;
               o.vel_x = entries[r.slot_index].vx;
               o.vel_y = entries[r.slot_index].vy;
            end
         end
         default: begin
         end
      endcase
      o.active_mask = 16'(occupied);
      return o;
   endfunction

   task automatic compare_field(string field, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, field, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         occupied = '0;
         foreach (entries[i]) entries[i] = '0;
         bounds.left_bound = LEFT_RST;
         bounds.right_bound = RIGHT_RST;
         bounds.top_bound = TOP_RST;
         bounds.bottom_bound = BOTTOM_RST;
         awaited_words.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_words.size() == 0) begin
               $display("%0t: unexpected result word: expected none, got %h", $time, rsp_word);
               errors++;
            end else begin
               want = awaited_words.pop_front();
               compare_field("result_status", 16'(want.result_status),
                             16'(rsp_word.result_status));
               compare_field("result_slot", 16'(want.result_slot), 16'(rsp_word.result_slot));
               compare_field("active_mask", want.active_mask, rsp_word.active_mask);
               compare_field("pos_x", want.pos_x, rsp_word.pos_x);
               compare_field("pos_y", want.pos_y, rsp_word.pos_y);
               compare_field("vel_x", 16'(unsigned'(want.vel_x)),
                             16'(unsigned'(rsp_word.vel_x)));
               compare_field("vel_y", 16'(unsigned'(want.vel_y)),
                             16'(unsigned'(rsp_word.vel_y)));
            end
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_LEFT:   bounds.left_bound = csr_wdata;
               CSR_RIGHT:  bounds.right_bound = csr_wdata;
               CSR_TOP:    bounds.top_bound = csr_wdata;
               CSR_BOTTOM: bounds.bottom_bound = csr_wdata;
               default: begin
               end
            endcase
         end
         if (start && !busy) awaited_words.push_back(advance_pool(req_word));
      end
      outstanding <= awaited_words.size();
   end

endmodule

// File: tb/sv/testbench.sv
// Testbench top for the slot pool motion table: clock, reset, command stimulus and verdict.
module testbench;
   import spmt_pkg::*;

   localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
   localparam int         PHASE_ITEMS = 135;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_word = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_word;
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LEFT;
   logic [15:0]          csr_wdata = '0;
   int                   mismatch_count;
   int                   pending;

   int issued = 0;
   int x_lo = int'(LEFT_RST);
   int x_hi = int'(RIGHT_RST);
   int y_lo = int'(TOP_RST);
   int y_hi = int'(BOTTOM_RST);

   always #2 clock = ~clock;

   slot_pool_motion_table dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   motion_table_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .rsp_strobe     (rsp_strobe),
      .rsp_word       (rsp_word),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   function automatic req_type make_req(logic [2:0] cmd, int x, int y, int vx, int vy,
                                        int slot);
      req_type r;
      r.command = cmd;
      r.new_x = 16'(x);
      r.new_y = 16'(y);
      r.new_vx = 8'(vx);
      r.new_vy = 8'(vy);
      r.slot_index = 4'(slot);
      return r;
   endfunction

   function automatic logic [15:0] in_span(int lo, int hi);
      int off;
      if (hi < lo) return 16'($urandom);
      off = $urandom_range(0, hi - lo);
      return 16'(lo + off);
   endfunction

   function automatic req_type random_command();
      req_type r;
      int      roll;
      int      v;
      r = make_req(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         r.command = CMD_SPAWN;
         if ($urandom_range(0, 9) != 0) begin
            r.new_x = in_span(x_lo, x_hi);
            r.new_y = in_span(y_lo, y_hi);
            v = $urandom_range(0, 16);
            r.new_vx = 8'(v - 8);
            v = $urandom_range(0, 16);
            r.new_vy = 8'(v - 8);
         end
      end else if (roll < 60) begin
         r.command = CMD_TICK;
      end else if (roll < 72) begin
         r.command = CMD_FREE;
      end else if (roll < 94) begin
         r.command = CMD_READ;
      end else if (roll < 97) begin
         r.command = CMD_CLEAR;
      end else begin
         r.command = CMD_FIRST_UNUSED + 3'($urandom_range(0, 2));
      end
      return r;
   endfunction

   task automatic issue(req_type r);
      @(negedge clock);
      start <= 1'b1;
      req_word <= r;
      do @(posedge clock); while (busy);
      if (r.command <= CMD_READ) issued++;
   endtask

   task automatic hold_off(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic settle();
      hold_off(1);
      while (pending != 0) hold_off(1);
      hold_off(4);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      @(negedge clock);
      start <= 1'b0;
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(value);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic write_bounds(int l, int r, int t, int b);
      x_lo = l;
      x_hi = r;
      y_lo = t;
      y_hi = b;
      write_reg(CSR_LEFT, l);
      write_reg(CSR_RIGHT, r);
      write_reg(CSR_TOP, t);
      write_reg(CSR_BOTTOM, b);
   endtask

   task automatic fill_pool();
      req_type r;
      for (int i = 0; i <= SLOTS_DEF; i++) begin
         r = random_command();
         r.command = CMD_SPAWN;
         issue(r);
      end
   endtask

   initial begin
      int idle_pct;
      int lo;
      int lo2;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      issue(make_req(CMD_READ, 0, 0, 0, 0, 0));
      issue(make_req(CMD_SPAWN, 32767, 32767, 127, 127, 15));
      issue(make_req(CMD_SPAWN, -32768, -32768, -128, -128, 0));
      issue(make_req(CMD_SPAWN, 0, 0, 0, 0, 0));
      issue(make_req(CMD_READ, 0, 0, 0, 0, 0));
      issue(make_req(CMD_READ, 0, 0, 0, 0, 1));
      issue(make_req(CMD_TICK, 0, 0, 0, 0, 0));
      issue(make_req(CMD_READ, 0, 0, 0, 0, 0));
      issue(make_req(CMD_FREE, 0, 0, 0, 0, 5));
      issue(make_req(CMD_FREE, 0, 0, 0, 0, 2));
      issue(make_req(CMD_READ, 0, 0, 0, 0, 2));
      issue(make_req(CMD_FIRST_UNUSED, -1, -1, -1, -1, 15));
      issue(make_req(CMD_FIRST_UNUSED + 3'd1, -1, -1, -1, -1, 15));
      issue(make_req(CMD_FIRST_UNUSED + 3'd2, -1, -1, -1, -1, 15));
      issue(make_req(CMD_SPAWN, 167, 159, 1, 0, 0));
      issue(make_req(CMD_SPAWN, -8, -8, 0, 0, 0));
      issue(make_req(CMD_TICK, 0, 0, 0, 0, 0));
      issue(make_req(CMD_READ, 0, 0, 0, 0, 0));
      issue(make_req(CMD_READ, 0, 0, 0, 0, 15));
      issue(make_req(CMD_CLEAR, 0, 0, 0, 0, 0));
      issue(make_req(CMD_READ, 0, 0, 0, 0, 0));
      fill_pool();
      issue(make_req(CMD_FREE, 0, 0, 0, 0, 7));
      issue(make_req(CMD_SPAWN, 1, 2, 3, 4, 0));

      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            settle();
            case (p)
               1: write_bounds(-32768, 32767, -32768, 32767);
               2: write_bounds(0, 0, 0, 0);
               3: write_bounds(32767, -32768, 32767, -32768);
               4: begin
                  lo = $urandom_range(0, 65000);
                  lo = lo - 32768;
                  lo2 = $urandom_range(0, 65000);
                  lo2 = lo2 - 32768;
                  write_bounds(lo, lo + $urandom_range(0, 300), lo2, lo2 + $urandom_range(0, 300));
               end
               default: write_bounds(int'(LEFT_RST), int'(RIGHT_RST), int'(TOP_RST),
                                     int'(BOTTOM_RST));
            endcase
         end
         idle_pct = (p < 2) ? 12 : (p < 4) ? 77 : 0;
         while (issued < (p + 1) * PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 4));
            if ($urandom_range(0, 99) < 3) settle();
            if ($urandom_range(0, 99) < 2) fill_pool();
            else issue(random_command());
         end
      end

      settle();
      hold_off(SLOTS_DEF + 8);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: sim.f
design/spmt_pkg.sv
design/spmt_entry_mem.sv
design/spmt_ctrl.sv
design/slot_pool_motion_table.sv
tb/sv/motion_table_checker.sv
tb/sv/testbench.sv
